// ===== src/fwm_pkg.sv =====
// Package for the filename wildcard matcher: pattern limits, wildcard
// character codes, register indexes and the sequencer state type.
// No dependencies.
package fwm_pkg;

    localparam int PATTERN_MAX = 12;
    localparam int POS_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CHAR_W-1:0] CH_ANY_ONE = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_ANY_RUN = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_0_3  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_4_7  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_8_11 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

// ===== src/filename_wildcard_matcher.sv =====
// Filename wildcard matcher top level: pattern registers, match sequencer
// and output register. Depends on fwm_pkg.
//
// Each accepted item is worked on one pattern position per cycle by a single
// compare unit. A nonzero character is worked in the run state, one step per
// pattern position stepped plus a final compare or end-of-pattern check (a dot
// may walk over up to twelve wildcards), and s_ready is low meanwhile. Once
// the name has failed, characters are absorbed in the idle state without
// entering the run state. The zero end item skips each trailing wildcard or
// dot in turn, then writes the verdict into the output register. The next
// item is accepted while a verdict still waits on m_valid; only a second end
// item waits for that slot to drain.
// Configuration writes are always accepted (cfg_ready is tied high).
module filename_wildcard_matcher
    import fwm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CHAR_W-1:0]      s_test_char,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_match
);

    logic [CFG_DATA_W-1:0] chars_0_3_reg, chars_4_7_reg, chars_8_11_reg;
    logic [POS_W-1:0]      length_reg;

    state_t                state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  failed_reg, failed_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_match_reg, m_match_next;

    logic [CHAR_W-1:0]      pat [PATTERN_MAX];
    logic [POS_W-1:0]       len_eff;
    logic [PATTERN_MAX-1:0] cut_mask;
    logic [PATTERN_MAX-1:0] le_mask;
    logic                   at_end;
    logic [CHAR_W-1:0]      p;
    logic                   s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_match   = m_match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_0_3_reg  <= '0;
            chars_4_7_reg  <= '0;
            chars_8_11_reg <= '0;
            length_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CHARS_0_3:  chars_0_3_reg  <= cfg_data;
                REG_CHARS_4_7:  chars_4_7_reg  <= cfg_data;
                REG_CHARS_8_11: chars_8_11_reg <= cfg_data;
                REG_LENGTH:     length_reg     <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern view and end-of-pattern test at the current position.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pat[i]     = chars_0_3_reg[i*CHAR_W +: CHAR_W];
            pat[i + 4] = chars_4_7_reg[i*CHAR_W +: CHAR_W];
            pat[i + 8] = chars_8_11_reg[i*CHAR_W +: CHAR_W];
        end
        len_eff = (length_reg > POS_W'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX) : length_reg;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            cut_mask[i] = (POS_W'(i) >= len_eff) || (pat[i] == CH_NUL);
            le_mask[i]  = (POS_W'(i) <= pos_reg);
        end
        at_end = (pos_reg >= POS_W'(PATTERN_MAX)) || (|(cut_mask & le_mask));
        p      = at_end ? CH_NUL : pat[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        m_match_reg <= m_match_next;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        failed_next  = failed_reg;
        char_next    = char_reg;
        m_match_next = m_match_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    char_next = s_test_char;
                    if (s_test_char == CH_NUL) begin
                        state_next = ST_FINISH;
                    end else if (!failed_reg) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (at_end) begin
                    failed_next = 1'b1;
                    state_next  = ST_IDLE;
                end else if (p == CH_ANY_ONE) begin
                    pos_next = pos_reg + POS_W'(1);
                    if (char_reg != CH_DOT) begin
                        state_next = ST_IDLE;
                    end
                end else if (p == CH_ANY_RUN) begin
                    if (char_reg != CH_DOT) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end else if (p == char_reg) begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    failed_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!at_end && (p == CH_ANY_ONE || p == CH_ANY_RUN || p == CH_DOT)) begin
                    pos_next = pos_reg + POS_W'(1);
                end else if (!m_valid_next) begin
                    m_valid_next = 1'b1;
                    m_match_next = !failed_reg && at_end;
                    pos_next     = '0;
                    failed_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== tb/tb_filename_wildcard_matcher.sv =====
`timescale 1ns / 1ps
// Testbench for filename_wildcard_matcher: streams names into the matcher and
// checks every match bit against its own model of the pattern walk.
// Depends on fwm_pkg and the filename_wildcard_matcher RTL.
module tb_filename_wildcard_matcher;
    import fwm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 850;
    localparam int HOLD_CYCLES   = 300;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_test_char = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic                   m_match;

    logic [CFG_DATA_W-1:0] pat_word [3] = '{default: '0};
    logic [3:0]            pat_len      = '0;
    logic [POS_W-1:0]      pat_pos      = '0;
    bit                    name_failed  = 1'b0;
    bit                    expected_match [$];

    int errors        = 0;
    int counted_items = 0;
    int cycles        = 0;
    bit calm          = 1'b0;
    bit hold_req      = 1'b0;

    always #5 aclk = ~aclk;

    filename_wildcard_matcher u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_test_char (s_test_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_match     (m_match)
    );

    function automatic logic [CHAR_W-1:0] pat_char_at(int i);
        if (i >= PATTERN_MAX) return CH_NUL;
        return pat_word[i / 4][(i % 4) * 8 +: 8];
    endfunction

    // clamped length, cut at the first zero byte
    function automatic int pat_limit();
        int len;
        len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
        for (int i = 0; i < len; i++) begin
            if (pat_char_at(i) == CH_NUL) return i;
        end
        return len;
    endfunction

    function automatic void match_step(logic [CHAR_W-1:0] c);
        int lim;
        int pos;
        logic [CHAR_W-1:0] p;
        lim = pat_limit();
        pos = int'(pat_pos);
        counted_items++;
        if (c == CH_NUL) begin
            while (pos < lim) begin
                p = pat_char_at(pos);
                if (p != CH_ANY_RUN && p != CH_ANY_ONE && p != CH_DOT) break;
                pos++;
            end
            expected_match.push_back(!name_failed && pos >= lim);
            pat_pos     = '0;
            name_failed = 1'b0;
            return;
        end
        if (name_failed) return;
        while (1'b1) begin
            if (pos >= lim) begin
                name_failed = 1'b1;
                break;
            end
            p = pat_char_at(pos);
            if (p == CH_ANY_ONE) begin
                pos++;
                if (c != CH_DOT) break;
            end else if (p == CH_ANY_RUN) begin
                if (c != CH_DOT) break;
                pos++;
            end else if (p == c) begin
                pos++;
                break;
            end else begin
                name_failed = 1'b1;
                break;
            end
        end
        pat_pos = pos[POS_W-1:0];
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        s_valid     <= 1'b1;
        s_test_char <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        match_step(c);
        if (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_name(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
        send_char(CH_NUL);
    endtask

    // wait for all verdicts, then let the sequencer finish its last item
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_match.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CHARS_0_3:  pat_word[0] = data;
            REG_CHARS_4_7:  pat_word[1] = data;
            REG_CHARS_8_11: pat_word[2] = data;
            REG_LENGTH:     pat_len = data[3:0];
        endcase
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                                input logic [CFG_DATA_W-1:0] w2, input logic [3:0] len);
        settle();
        cfg_write(REG_CHARS_0_3, w0, 1'b0);
        cfg_write(REG_CHARS_4_7, w1, 1'b0);
        cfg_write(REG_CHARS_8_11, w2, 1'b0);
        cfg_write(REG_LENGTH, {{(CFG_DATA_W-4){1'b0}}, len}, 1'b1);
    endtask

    task automatic load_text(input string txt, input logic [3:0] len);
        logic [CFG_DATA_W-1:0] w [3];
        w = '{default: '0};
        for (int i = 0; i < txt.len() && i < PATTERN_MAX; i++) w[i / 4][(i % 4) * 8 +: 8] = txt[i];
        load_pattern(w[0], w[1], w[2], len);
    endtask

    function automatic logic [CHAR_W-1:0] pick_pat_char();
        case ($urandom_range(9))
            0, 1:    return CH_ANY_RUN;
            2:       return CH_ANY_ONE;
            3:       return CH_DOT;
            9:       return CHAR_W'($urandom_range(255));
            default: return CHAR_W'("a" + $urandom_range(2));
        endcase
    endfunction

    // anything but a dot or zero
    function automatic logic [CHAR_W-1:0] filler_char();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(3) != 0) return CHAR_W'("a" + $urandom_range(2));
        c = CHAR_W'($urandom_range(1, 255));
        return (c == CH_DOT) ? "b" : c;
    endfunction

    task automatic send_random_name(input int lim);
        logic [CHAR_W-1:0] chars [$];
        logic [CHAR_W-1:0] p;
        int kind;
        int at;
        kind = $urandom_range(9);
        if (kind >= 8) begin
            repeat ($urandom_range(0, 8)) chars.push_back(CHAR_W'($urandom_range(1, 255)));
        end else begin
            for (int i = 0; i < lim; i++) begin
                p = pat_char_at(i);
                if (p == CH_ANY_RUN) begin
                    repeat ($urandom_range(0, 3)) chars.push_back(filler_char());
                end else if (p == CH_ANY_ONE) begin
                    if ($urandom_range(3) != 0) chars.push_back(filler_char());
                end else begin
                    chars.push_back(p);
                end
            end
            if (kind == 7 && chars.size() > 0) begin
                at = int'($urandom_range(chars.size() - 1));
                case ($urandom_range(2))
                    0:       chars[at] = CHAR_W'($urandom_range(1, 255));
                    1:       chars.delete(at);
                    default: chars.insert(at, filler_char());
                endcase
            end
        end
        foreach (chars[i]) send_char(chars[i]);
        send_char(CH_NUL);
    endtask

    task automatic test_empty_pattern();
        send_name("");
        send_name("a");
    endtask

    task automatic test_wildcard_rules();
        load_text("*.c?", 4'd4);
        send_name("a.cd");
        send_name(".c");
        send_name("ab");
        load_text("?.x", 4'd3);
        send_name(".x");
    endtask

    task automatic test_extreme_chars();
        load_pattern(32'h7F8001FF, 32'h2A2A2A2A, 32'h2E3F2E3F, 4'd15);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(CH_NUL);
        send_char(8'hFE);
        send_char(CH_NUL);
        // zero byte inside the length ends the pattern
        load_pattern(32'h2E006162, '0, '0, 4'd4);
        send_name("ba");
        send_name("bx.");
    endtask

    task automatic test_midname_write();
        load_text("a*", 4'd2);
        send_char("a");
        load_text("ab", 4'd2);
        send_char("b");
        send_char(CH_NUL);
    endtask

    task automatic test_output_stall();
        load_text("*.?", 4'd3);
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (6) begin
            send_name("x.y");
            send_name("");
        end
        calm = 1'b0;
    endtask

    task automatic test_random_names();
        logic [CFG_DATA_W-1:0] w [3];
        logic [3:0] len;
        int target;
        int phase;
        target = counted_items + RANDOM_ITEMS;
        phase  = 0;
        while (counted_items < target) begin
            calm = (phase >= 2 && phase < 4);
            foreach (w[k]) begin
                if ($urandom_range(7) == 0) begin
                    w[k] = $urandom();
                end else begin
                    for (int b = 0; b < 4; b++) w[k][b * 8 +: 8] = pick_pat_char();
                end
            end
            case ($urandom_range(7))
                0:       len = 4'($urandom_range(13, 15));
                1:       len = '0;
                default: len = 4'($urandom_range(1, 12));
            endcase
            if (phase == 0) begin
                w   = '{default: '1};
                len = 4'd15;
            end
            load_pattern(w[0], w[1], w[2], len);
            repeat ($urandom_range(6, 14)) send_random_name(pat_limit());
            phase++;
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin : receiver
        bit want;
        int hold_left;
        if (aresetn && m_valid && m_ready) begin
            if (expected_match.size() == 0) begin
                $display("%0t: match bit with none expected: expected none, actual %0b",
                         $time, m_match);
                errors++;
            end else begin
                want = expected_match.pop_front();
                if (m_match !== want) begin
                    $display("%0t: match mismatch: expected %0b, actual %0b", $time, want, m_match);
                    errors++;
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_pattern();
        test_wildcard_rules();
        test_extreme_chars();
        test_midname_write();
        test_output_stall();
        test_random_names();
        settle();
        if (errors == 0 && expected_match.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
